// File: rtl/assert_macros.svh
// Assertion macros for the checker file of the seat heater thermostat.
// Self-contained; the enclosing module must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is applied
`define SHT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked implication, switched off while reset is applied
`define SHT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/sht_pkg.sv
// Package for the seat heater thermostat: field widths, register indexes,
// reset values, the configuration struct and the duty constants. No dependencies.
package sht_pkg;

	localparam int TEMP_W   = 8;
	localparam int LEVEL_W  = 2;
	localparam int DUTY_W   = 6;
	localparam int TIMER_W  = 19;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = TIMER_W;
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 16;

	// Duty counter runs 0..60, heater on for counts 0..46 near target
	localparam logic [DUTY_W-1:0] DUTY_TOP     = 6'd60;
	localparam logic [DUTY_W-1:0] DUTY_ON_LAST = 6'd46;

	// Item kinds carried in tuser
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SET  = 1'b1;

	// Heat levels
	localparam logic [LEVEL_W-1:0] LEVEL_OFF   = 2'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 2'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_TWO   = 2'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_THREE = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_ONE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_TWO   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_THREE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_SAVE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_LOW   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BURN_ONE     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BURN_TWO     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BURN_THREE   = 3'd7;

	// Reset values of the registers
	localparam logic [TEMP_W-1:0]  RST_TARGET_ONE   = 8'd34;
	localparam logic [TEMP_W-1:0]  RST_TARGET_TWO   = 8'd38;
	localparam logic [TEMP_W-1:0]  RST_TARGET_THREE = 8'd42;
	localparam logic [TEMP_W-1:0]  RST_TARGET_SAVE  = 8'd29;
	localparam logic [TEMP_W-1:0]  RST_SENSOR_LOW   = 8'd0;
	localparam logic [TIMER_W-1:0] RST_BURN_ONE     = 19'd30000;
	localparam logic [TIMER_W-1:0] RST_BURN_TWO     = 19'd60000;
	localparam logic [TIMER_W-1:0] RST_BURN_THREE   = 19'd270000;

	typedef struct packed {
		logic [TEMP_W-1:0]  target_one;
		logic [TEMP_W-1:0]  target_two;
		logic [TEMP_W-1:0]  target_three;
		logic [TEMP_W-1:0]  target_save;
		logic [TEMP_W-1:0]  sensor_low;
		logic [TIMER_W-1:0] burn_one;
		logic [TIMER_W-1:0] burn_two;
		logic [TIMER_W-1:0] burn_three;
	} cfg_regs_t;

endpackage

// File: rtl/sht_cfg.sv
// Configuration register file of the seat heater thermostat.
// Depends on sht_pkg for indexes, reset values and cfg_regs_t.
module sht_cfg import sht_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_regs_t             regs
);

	cfg_regs_t regs_q;

	// Register writes; every index of the 3-bit space maps to a register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.target_one   <= RST_TARGET_ONE;
			regs_q.target_two   <= RST_TARGET_TWO;
			regs_q.target_three <= RST_TARGET_THREE;
			regs_q.target_save  <= RST_TARGET_SAVE;
			regs_q.sensor_low   <= RST_SENSOR_LOW;
			regs_q.burn_one     <= RST_BURN_ONE;
			regs_q.burn_two     <= RST_BURN_TWO;
			regs_q.burn_three   <= RST_BURN_THREE;
		end else if (wr_en) begin
			case (wr_index)
				REG_TARGET_ONE:   regs_q.target_one   <= wr_data[TEMP_W-1:0];
				REG_TARGET_TWO:   regs_q.target_two   <= wr_data[TEMP_W-1:0];
				REG_TARGET_THREE: regs_q.target_three <= wr_data[TEMP_W-1:0];
				REG_TARGET_SAVE:  regs_q.target_save  <= wr_data[TEMP_W-1:0];
				REG_SENSOR_LOW:   regs_q.sensor_low   <= wr_data[TEMP_W-1:0];
				REG_BURN_ONE:     regs_q.burn_one     <= wr_data;
				REG_BURN_TWO:     regs_q.burn_two     <= wr_data;
				REG_BURN_THREE:   regs_q.burn_three   <= wr_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// File: rtl/seat_heater_thermostat.sv
// Seat heater thermostat: top level with input stage, state update and output register.
// Depends on sht_pkg and sht_cfg.
//
// Usage:
// Items arrive on the s_ stream. tuser is 0 for a 10 ms tick and 1 for a level set.
// Every item yields exactly one result on the m_ stream: heater drive, current level,
// last set level and current target temperature.
// Registers are written on the cfg_ channel (index 0..7, data in the low bits);
// cfg_ready is always high. Writes are expected only while the block is idle.
// Path: an item is held in the input register and then in the output register; a
// stalled output register keeps it waiting in the input register.
// Throughput: one item per clock while results are taken; the thermostat state is updated
// in the single cycle in which an item leaves the input register, so ticks may follow back to back.
// Stall: the output register holds its result while m_tready is low; one further
// item waits in the input register, then s_tready drops until the result is taken.
// Reset: all state clears (level off, target 0, heater off, duty and burn timer zero)
// and the registers take their default targets and burn thresholds.
module seat_heater_thermostat import sht_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [1:0] level_value, [2] power_on, [3] display_inhibit, [4] power_save,
	// [5] seat_occupied, [6] error_stop, [14:7] seat_temp, [15] zero
	input  logic [S_DATA_W-1:0]   s_tdata,
	// [0] op
	input  logic                  s_tuser,
	// output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] heater_on, [2:1] level_now, [4:3] level_set, [12:5] target_now, [15:13] zero
	output logic [M_DATA_W-1:0]   m_tdata,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_regs_t regs;

	logic                  valid_s1;
	logic                  op_s1;
	logic [S_DATA_W-1:0]   data_s1;

	logic                  m_valid_q;
	logic [M_DATA_W-1:0]   m_data_q;

	logic [DUTY_W-1:0]     duty_q;
	logic [LEVEL_W-1:0]    level_q;
	logic [LEVEL_W-1:0]    level_set_q;
	logic [TEMP_W-1:0]     target_q;
	logic [TIMER_W-1:0]    timer_q;
	logic                  watch_q;
	logic                  reduced_q;
	logic                  heater_q;

	logic                  out_free;
	logic                  advance;

	logic [DUTY_W-1:0]     duty_d;
	logic [LEVEL_W-1:0]    level_d;
	logic [LEVEL_W-1:0]    level_set_d;
	logic [TEMP_W-1:0]     target_d;
	logic [TIMER_W-1:0]    timer_d;
	logic                  watch_d;
	logic                  reduced_d;
	logic                  heater_d;

	sht_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs     (regs)
	);

	assign cfg_ready = 1'b1;

	// Handshakes
	assign out_free = !m_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			data_s1 <= s_tdata;
		end
	end

	// Next state for the item in the input register
	always_comb begin
		logic [LEVEL_W-1:0] level_in;
		logic               power;
		logic               inhibit;
		logic               save;
		logic               occupied;
		logic               stop;
		logic [TEMP_W-1:0]  temp;

		level_in = data_s1[1:0];
		power    = data_s1[2];
		inhibit  = data_s1[3];
		save     = data_s1[4];
		occupied = data_s1[5];
		stop     = data_s1[6];
		temp     = data_s1[14:7];

		duty_d      = duty_q;
		level_d     = level_q;
		level_set_d = level_set_q;
		target_d    = target_q;
		timer_d     = timer_q;
		watch_d     = watch_q;
		reduced_d   = reduced_q;
		heater_d    = heater_q;

		if (op_s1 == OP_SET) begin
			level_d     = level_in;
			level_set_d = level_in;
		end else begin
			duty_d = (duty_q < DUTY_TOP) ? duty_q + 1'b1 : '0;
			if (!power || inhibit) begin
				heater_d  = 1'b0;
				timer_d   = '0;
				reduced_d = 1'b0;
			end else begin
				if (save) begin
					// Power save: any nonzero level drops to one
					if (level_q != LEVEL_OFF) begin
						level_d  = LEVEL_ONE;
						target_d = regs.target_save;
					end else begin
						heater_d = 1'b0;
						target_d = '0;
					end
					timer_d   = '0;
					reduced_d = 1'b0;
				end else begin
					case (level_q)
						LEVEL_ONE: begin
							target_d  = regs.target_one;
							timer_d   = '0;
							reduced_d = 1'b0;
						end
						LEVEL_TWO: begin
							target_d  = regs.target_two;
							timer_d   = '0;
							reduced_d = 1'b0;
						end
						LEVEL_THREE: begin
							if (!reduced_q)
								target_d = regs.target_three;
							if (occupied) begin
								if (temp >= target_d)
									watch_d = 1'b1;
							end else begin
								target_d  = regs.target_three;
								watch_d   = 1'b0;
								timer_d   = '0;
								reduced_d = 1'b0;
							end
							// Burn timer: saturates at the third threshold
							if (watch_d) begin
								if (timer_d < regs.burn_three)
									timer_d = timer_d + 1'b1;
								else
									timer_d = regs.burn_three;
								if (timer_d < regs.burn_one) begin
									// first stage, target unchanged
								end else if (timer_d < regs.burn_two) begin
									target_d  = regs.target_three - 8'd1;
									reduced_d = 1'b1;
								end else if (timer_d < regs.burn_three) begin
									target_d  = regs.target_three - 8'd2;
									reduced_d = 1'b1;
								end else begin
									target_d  = regs.target_one;
									reduced_d = 1'b1;
								end
							end
						end
						default: begin
							heater_d  = 1'b0;
							target_d  = '0;
							timer_d   = '0;
							reduced_d = 1'b0;
						end
					endcase
				end
				// Heater drive, held under error stop
				if (!stop) begin
					if (temp == regs.sensor_low)
						heater_d = 1'b1;
					else if (temp >= target_d)
						heater_d = 1'b0;
					else if ({1'b0, temp} + 9'd1 < {1'b0, target_d})
						heater_d = 1'b1;
					else
						heater_d = (duty_d <= DUTY_ON_LAST);
				end
			end
		end
	end

	// Thermostat state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q      <= '0;
			level_q     <= LEVEL_OFF;
			level_set_q <= LEVEL_OFF;
			target_q    <= '0;
			timer_q     <= '0;
			watch_q     <= 1'b0;
			reduced_q   <= 1'b0;
			heater_q    <= 1'b0;
		end else if (advance) begin
			duty_q      <= duty_d;
			level_q     <= level_d;
			level_set_q <= level_set_d;
			target_q    <= target_d;
			timer_q     <= timer_d;
			watch_q     <= watch_d;
			reduced_q   <= reduced_d;
			heater_q    <= heater_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			m_data_q <= {3'b000, target_d, level_set_d, level_d, heater_d};
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// File: rtl/sht_checker.sv
// Port-level checks for the seat heater thermostat, bound to the top level.
// Depends on sht_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sht_checker import sht_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [M_DATA_W-1:0]   m_tdata
);

	// A stalled result keeps its payload
	`SHT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

	// An empty or draining output never backs up the input side
	`SHT_ASSERT_IMPL(a_no_false_stall, !m_tvalid || m_tready, s_tready, "input stalled with room downstream")

	// Every new result comes from an earlier input transaction
	`SHT_ASSERT_IMPL(a_latency, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "result without transaction")

	// Padding bits of a result stay zero
	`SHT_ASSERT_IMPL(a_pad_zero, m_tvalid, m_tdata[M_DATA_W-1:13] == 3'b000, "result padding not zero")

endmodule

bind seat_heater_thermostat sht_checker u_sht_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);
